[hw/rtl/rde_pkg.sv]
// ----------------------------------------------------------------------------
// Radix digit emitter package
// Shared constants, types and the digit-to-symbol function of the emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

   localparam int unsigned VALUE_BITS_DEFAULT    = 64;
   localparam int unsigned MAX_DIGITS_DEFAULT    = 64;
   localparam int unsigned ALPHABET_SIZE_DEFAULT = 66;

   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned RADIX_W  = 7;
   localparam int unsigned DIGIT_W  = 7;
   localparam int unsigned SYMBOL_W = 7;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;

   // ASCII bounds of the three symbol groups
   localparam int unsigned SYM_DIGIT_FIRST = 48;
   localparam int unsigned SYM_DIGIT_LAST  = 57;
   localparam int unsigned SYM_UPPER_FIRST = 65;
   localparam int unsigned SYM_UPPER_LAST  = 90;
   localparam int unsigned SYM_LOWER_FIRST = 97;
   localparam int unsigned SYM_LOWER_LAST  = 126;

   localparam int unsigned UPPER_START = 10;
   localparam int unsigned LOWER_START = 36;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT_READ,
      ST_EMIT_WAIT
   } state_type;

   typedef struct packed {
      logic start;
      logic use_input;
   } div_ctrl_type;

   typedef struct packed {
      logic               done;
      logic               quot_nz;
      logic [DIGIT_W-1:0] remainder;
   } div_stat_type;

   function automatic logic [SYMBOL_W-1:0] digit_symbol(input logic [DIGIT_W-1:0] d);
      logic [SYMBOL_W-1:0] sym;
      if (d < DIGIT_W'(UPPER_START)) begin
         sym = d + SYMBOL_W'(SYM_DIGIT_FIRST);
      end else if (d < DIGIT_W'(LOWER_START)) begin
         sym = d + SYMBOL_W'(SYM_UPPER_FIRST - UPPER_START);
      end else begin
         sym = d + SYMBOL_W'(SYM_LOWER_FIRST - LOWER_START);
      end
      return sym;
   endfunction

endpackage

[hw/rtl/radix_digit_emitter_unit.sv]
// ----------------------------------------------------------------------------
// Radix digit emitter
// Converts an unsigned value into ASCII digit symbols in a chosen base.
// ----------------------------------------------------------------------------
// Usage: write the base (2 to 66) on the csr_ channel while the block is idle;
// it is always ready and resets to 10. Bases out of range are clamped.
// A value enters on the req_ channel; its digits leave on the rsp_ channel,
// most significant first, one transfer per digit, with rsp_last_digit set on
// the final one. Zero gives a single '0'.
// Each digit comes from the bit-serial divider, which produces one quotient
// bit per cycle; digits are then read back from the digit store one at a
// time while the receiver takes them. One value is converted at a time;
// the next is accepted once the final digit sits in the output register.
// When the receiver stalls, the output register holds its digit and the
// read-back waits. Reset clears the control state and the output valid;
// the digit store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module radix_digit_emitter_unit #(
   parameter int unsigned VALUE_BITS    = rde_pkg::VALUE_BITS_DEFAULT,
   parameter int unsigned MAX_DIGITS    = rde_pkg::MAX_DIGITS_DEFAULT,
   parameter int unsigned ALPHABET_SIZE = rde_pkg::ALPHABET_SIZE_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rde_pkg::RADIX_W-1:0]    csr_radix,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rde_pkg::VALUE_W-1:0]    req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rde_pkg::SYMBOL_W-1:0]   rsp_symbol,
   output logic                           rsp_last_digit
);

   localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
   localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

   rde_pkg::state_type             state_ff, state_in;
   logic [rde_pkg::RADIX_W-1:0]    radix_ff;
   logic [rde_pkg::RADIX_W-1:0]    radix_eff;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [IDX_W-1:0]               rd_idx_ff, rd_idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rde_pkg::SYMBOL_W-1:0]   rsp_symbol_ff, rsp_symbol_in;
   logic                           rsp_last_ff, rsp_last_in;

   rde_pkg::div_ctrl_type          div_ctrl;
   rde_pkg::div_stat_type          div_stat;
   logic                           wr_en;
   logic                           rd_en;
   logic [rde_pkg::SYMBOL_W-1:0]   rd_data;
   logic                           out_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= rde_pkg::RADIX_RESET;
      end else if (csr_valid) begin
         radix_ff <= csr_radix;
      end
   end

   always_comb begin
      if (radix_ff < rde_pkg::RADIX_MIN) begin
         radix_eff = rde_pkg::RADIX_MIN;
      end else if (radix_ff > rde_pkg::RADIX_W'(ALPHABET_SIZE)) begin
         radix_eff = rde_pkg::RADIX_W'(ALPHABET_SIZE);
      end else begin
         radix_eff = radix_ff;
      end
   end

   rde_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (req_value[VALUE_BITS-1:0]),
      .divisor  (radix_eff),
      .stat     (div_stat)
   );

   rde_digit_store #(
      .DEPTH (MAX_DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (rde_pkg::digit_symbol(div_stat.remainder)),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      rd_idx_in          = rd_idx_ff;
      div_ctrl.start     = 1'b0;
      div_ctrl.use_input = 1'b0;
      wr_en              = 1'b0;
      rd_en              = 1'b0;
      req_ready          = 1'b0;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_symbol_in      = rsp_symbol_ff;
      rsp_last_in        = rsp_last_ff;
      case (state_ff)
         rde_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               div_ctrl.start     = 1'b1;
               div_ctrl.use_input = 1'b1;
               count_in           = '0;
               state_in           = rde_pkg::ST_DIVIDE;
            end
         end
         rde_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               // Digits beyond the store are the most significant ones and
               // are dropped; the division still runs to the end.
               if (count_ff < CNT_W'(MAX_DIGITS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (div_stat.quot_nz) begin
                  div_ctrl.start = 1'b1;
               end else begin
                  rd_idx_in = wr_en ? count_ff[IDX_W-1:0] : IDX_W'(MAX_DIGITS - 1);
                  state_in  = rde_pkg::ST_EMIT_READ;
               end
            end
         end
         rde_pkg::ST_EMIT_READ: begin
            if (out_free) begin
               rd_en    = 1'b1;
               state_in = rde_pkg::ST_EMIT_WAIT;
            end
         end
         rde_pkg::ST_EMIT_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_symbol_in = rd_data;
            rsp_last_in   = rd_idx_ff == '0;
            if (rd_idx_ff == '0) begin
               state_in = rde_pkg::ST_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff - 1'b1;
               state_in  = rde_pkg::ST_EMIT_READ;
            end
         end
         default: begin
            state_in = rde_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= rde_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_symbol     = rsp_symbol_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule

[hw/rtl/rde_divider.sv]
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division of the value by the radix, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rde_divider #(
   parameter int unsigned VALUE_BITS = rde_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rde_pkg::div_ctrl_type         ctrl,
   input  logic [VALUE_BITS-1:0]         dividend,
   input  logic [rde_pkg::RADIX_W-1:0]   divisor,
   output rde_pkg::div_stat_type         stat
);

   localparam int unsigned CNT_W = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0]        dvd_ff, dvd_in;
   logic [rde_pkg::DIGIT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic                         qnz_ff, qnz_in;

   logic [rde_pkg::DIGIT_W:0]    trial;
   logic [rde_pkg::DIGIT_W:0]    diff;
   logic                         fits;

   // The dividend register shifts left; quotient bits enter at the bottom,
   // so after a full pass it holds the quotient.
   assign trial = {rem_ff, dvd_ff[VALUE_BITS-1]};
   assign fits  = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      qnz_in  = qnz_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         dvd_in  = ctrl.use_input ? dividend : dvd_ff;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         qnz_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[rde_pkg::DIGIT_W-1:0] : trial[rde_pkg::DIGIT_W-1:0];
         dvd_in = {dvd_ff[VALUE_BITS-2:0], fits};
         qnz_in = qnz_ff | fits;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      qnz_ff <= qnz_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done      = done_ff;
   assign stat.quot_nz   = qnz_ff;
   assign stat.remainder = rem_ff;

endmodule

[hw/rtl/rde_digit_store.sv]
// ----------------------------------------------------------------------------
// Digit store
// Single-port-write, registered-read memory of digit symbols.
// ----------------------------------------------------------------------------
module rde_digit_store #(
   parameter int unsigned DEPTH = rde_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [rde_pkg::SYMBOL_W-1:0]   wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [rde_pkg::SYMBOL_W-1:0]   rd_data
);

   logic [rde_pkg::SYMBOL_W-1:0] mem [DEPTH];
   logic [rde_pkg::SYMBOL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/rde_checker.sv]
// ----------------------------------------------------------------------------
// Radix digit emitter checker
// Port-level assertions on the emitter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rde_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rde_pkg::SYMBOL_W-1:0]   rsp_symbol,
   input logic                           rsp_last_digit
);

   // A stalled digit must be held unchanged until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol)
                                 && $stable(rsp_last_digit))
      else $error("stalled digit changed before its transfer");

   // Every digit shown is a symbol of the alphabet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_symbol >= rde_pkg::SYMBOL_W'(rde_pkg::SYM_DIGIT_FIRST) &&
          rsp_symbol <= rde_pkg::SYMBOL_W'(rde_pkg::SYM_DIGIT_LAST)) ||
         (rsp_symbol >= rde_pkg::SYMBOL_W'(rde_pkg::SYM_UPPER_FIRST) &&
          rsp_symbol <= rde_pkg::SYMBOL_W'(rde_pkg::SYM_UPPER_LAST)) ||
         (rsp_symbol >= rde_pkg::SYMBOL_W'(rde_pkg::SYM_LOWER_FIRST) &&
          rsp_symbol <= rde_pkg::SYMBOL_W'(rde_pkg::SYM_LOWER_LAST)))
      else $error("digit symbol outside the alphabet");

   // Only one value is converted at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new value accepted during a conversion");

   // Reset leaves no digit pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("digit pending after reset");

endmodule

bind radix_digit_emitter_unit rde_checker u_rde_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_symbol     (rsp_symbol),
   .rsp_last_digit (rsp_last_digit)
);
